[rtl/indexed_removal_sequence_buffer_top_macros.svh]
// Assertion helpers used by the checker file.
// Both macros assume signals named clk and rst_n in the enclosing scope.
`ifndef INDEXED_REMOVAL_SEQUENCE_BUFFER_TOP_MACROS_SVH
`define INDEXED_REMOVAL_SEQUENCE_BUFFER_TOP_MACROS_SVH

// same-cycle implication
`define IRSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irsb_pkg.sv]
`default_nettype none

package irsb_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_NULL = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic op_append;  // store word at tail
        logic op_full;    // append refused
        logic op_clear;
        logic op_null;    // remove refused
        logic op_nop;     // unused kind code
        logic rm_start;   // read word at position, load pointers
        logic fetch;      // removed word arrives from memory
        logic shift;      // move one word down
        logic rd_next;    // read next word above the gap
        logic rm_done;    // close out a remove
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic remove_ok;
        logic more;
    } sts_t;

endpackage

`default_nettype wire

[rtl/indexed_removal_sequence_buffer_top.sv]
// Channel   Handshake            Fields
// --------  -------------------  ------------------------------
// command   start / busy         kind, value, position
// result    done (one cycle)     status, removed, count
//
// Append, clear, refused requests: transfer taken when start && !busy, result
//   strobed on the next cycle; busy stays low, so commands can go every cycle.
// Remove at position p with count n: busy from the transfer through a fetch state and one
//   shift state per word above p, one word moved down per cycle through the read and write ports.
// Reset: count goes to zero; stored words are not cleared and need no sweep.
// The result side has no stall; done is high for exactly one cycle.
`default_nettype none

module indexed_removal_sequence_buffer_top
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] value,
    input  wire logic [7:0]  position,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      removed,
    output logic [6:0]       count
);

    irsb_pkg::cmd_t cmd;
    irsb_pkg::sts_t sts;

    irsb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    irsb_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .removed  (removed),
        .count    (count)
    );

endmodule

`default_nettype wire

[rtl/irsb_ctrl.sv]
`default_nettype none

module irsb_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     kind,
    input  wire irsb_pkg::sts_t sts,
    output irsb_pkg::cmd_t      cmd,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        irsb_pkg::KIND_APPEND:
                        begin
                            cmd.op_append = !sts.full;
                            cmd.op_full   = sts.full;
                        end
                        irsb_pkg::KIND_REMOVE:
                        begin
                            if (sts.remove_ok)
                            begin
                                cmd.rm_start = 1'b1;
                                state_next   = ST_FETCH;
                            end
                            else
                            begin
                                cmd.op_null = 1'b1;
                            end
                        end
                        irsb_pkg::KIND_CLEAR:
                        begin
                            cmd.op_clear = 1'b1;
                        end
                        default:
                        begin
                            cmd.op_nop = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH, ST_SHIFT:
            begin
                cmd.fetch = (state_reg == ST_FETCH);
                cmd.shift = (state_reg == ST_SHIFT);
                if (sts.more)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    cmd.rm_done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

[rtl/irsb_datapath.sv]
`default_nettype none

module irsb_datapath
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire irsb_pkg::cmd_t cmd,
    output irsb_pkg::sts_t      sts,
    input  wire logic [31:0]    value,
    input  wire logic [7:0]     position,
    output logic                done,
    output logic [1:0]          status,
    output logic [31:0]         removed,
    output logic [6:0]          count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         rd_ptr_reg;
    logic [CW-1:0]         rd_ptr_next;
    logic [AW-1:0]         wr_ptr_reg;
    logic [AW-1:0]         wr_ptr_next;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [DATA_WIDTH-1:0] word_out;

    logic                  done_reg;
    logic                  done_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [31:0]           removed_reg;
    logic [31:0]           removed_next;

    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.remove_ok = (32'(position) < 32'(count_reg));
    assign sts.more      = (rd_ptr_reg < count_reg);

    // one read port, registered; one write port
    assign rd_addr = cmd.rm_start ? AW'(position) : rd_ptr_reg[AW-1:0];
    assign wr_en   = cmd.op_append || cmd.shift;
    assign wr_addr = cmd.shift ? wr_ptr_reg : count_reg[AW-1:0];
    assign wr_data = cmd.shift ? rdata_reg : DATA_WIDTH'(value);

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.op_clear)
        begin
            count_next = '0;
        end
        else if (cmd.op_append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.rm_done)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (cmd.rm_start)
        begin
            rd_ptr_next = CW'(position) + CW'(1);
            wr_ptr_next = AW'(position);
        end
        else
        begin
            if (cmd.rd_next)
            begin
                rd_ptr_next = rd_ptr_reg + CW'(1);
            end
            if (cmd.shift)
            begin
                wr_ptr_next = wr_ptr_reg + AW'(1);
            end
        end
    end

    // removed word comes straight from memory when the remove ends in its fetch cycle
    assign word_out  = cmd.fetch ? rdata_reg : word_reg;
    assign word_next = word_out;

    assign done_next = cmd.op_append || cmd.op_full || cmd.op_clear ||
                       cmd.op_null || cmd.op_nop || cmd.rm_done;

    always_comb
    begin
        priority if (cmd.op_full)
        begin
            status_next = irsb_pkg::STATUS_FULL;
        end
        else if (cmd.op_null)
        begin
            status_next = irsb_pkg::STATUS_NULL;
        end
        else
        begin
            status_next = irsb_pkg::STATUS_DONE;
        end
    end

    assign removed_next = cmd.rm_done ? 32'(word_out) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        word_reg   <= word_next;
        if (done_next)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign removed = removed_reg;
    assign count   = 7'(count_reg);

endmodule

`default_nettype wire

[rtl/irsb_checker.sv]
`default_nettype none

`include "indexed_removal_sequence_buffer_top_macros.svh"

module irsb_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  kind,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [31:0] removed,
    input wire logic [6:0]  count
);

    `IRSB_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")
    `IRSB_ASSERT_NEXT(a_busy_needs_xfer, !busy && !start, !busy, "busy without a transfer")
    `IRSB_ASSERT_NOW(a_end_gives_result, $fell(busy), done, "remove ended without result")
    `IRSB_ASSERT_NOW(a_refused_zero, done && status != irsb_pkg::STATUS_DONE, removed == 32'd0,
        "refused request returned a word")
    `IRSB_ASSERT_NEXT(a_clear_result, start && !busy && kind == irsb_pkg::KIND_CLEAR,
        done && count == 7'd0, "clear did not report empty")

endmodule

bind indexed_removal_sequence_buffer_top irsb_checker u_checker (.*);

`default_nettype wire

[sim/tb_indexed_removal_sequence_buffer_top.sv]
`timescale 1ns / 100ps

module tb_indexed_removal_sequence_buffer_top;

    localparam int DEPTH = 64;
    localparam logic [1:0] KIND_NOP = 2'd3;  // unused code, must leave the store alone

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed;
        logic [6:0]  count;
    } result_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [7:0]  position;
        int          reps;
        bit          pinned;
        result_t     res;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = KIND_NOP;
    logic [31:0] value = '0;
    logic [7:0]  position = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] removed;
    logic [6:0]  count;

    // typed-in expectation riding along with the command
    bit          pin_valid = 1'b0;
    result_t     pin_res = '0;

    logic [31:0] seq_words [DEPTH];
    int          seq_len = 0;
    result_t     pending_results [$];
    int          errors = 0;
    int          drv_len = 0;
    int          idle_pct = 0;

    indexed_removal_sequence_buffer_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .removed  (removed),
        .count    (count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic result_t seq_apply(input logic [1:0] k, input logic [31:0] v,
                                          input logic [7:0] p);
        result_t res;
        int      i;
        res = '0;
        res.status = irsb_pkg::STATUS_DONE;
        case (k)
            irsb_pkg::KIND_APPEND:
            begin
                if (seq_len >= DEPTH)
                begin
                    res.status = irsb_pkg::STATUS_FULL;
                end
                else
                begin
                    seq_words[seq_len] = v;
                    seq_len++;
                end
            end
            irsb_pkg::KIND_REMOVE:
            begin
                if (int'(p) >= seq_len)
                begin
                    res.status = irsb_pkg::STATUS_NULL;
                end
                else
                begin
                    res.removed = seq_words[p];
                    for (i = int'(p); i + 1 < seq_len; i++)
                    begin
                        seq_words[i] = seq_words[i + 1];
                    end
                    seq_len--;
                end
            end
            irsb_pkg::KIND_CLEAR:
            begin
                seq_len = 0;
            end
            default:
            begin
            end
        endcase
        res.count = 7'(seq_len);
        return res;
    endfunction

    function automatic plan_row_t plan_row(input logic [1:0] k, input logic [31:0] v,
                                           input logic [7:0] p, input int n, input bit pin,
                                           input logic [1:0] st, input logic [31:0] rm,
                                           input logic [6:0] cnt);
        plan_row_t r;
        r.kind = k;
        r.value = v;
        r.position = p;
        r.reps = n;
        r.pinned = pin;
        r.res.status = st;
        r.res.removed = rm;
        r.res.count = cnt;
        return r;
    endfunction

    // result check first, then the command accepted at this edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result: status %0d removed %h count %0d",
                                 $realtime, status, removed, count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || removed !== want.removed ||
                        count !== want.count)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: exp/act status %0d/%0d removed %h/%h count %0d/%0d",
                                     $realtime, want.status, status, want.removed, removed,
                                     want.count, count);
                    end
                end
            end
            if (start && !busy)
            begin
                want = seq_apply(kind, value, position);
                if (pin_valid)
                    want = pin_res;
                pending_results.push_back(want);
            end
        end
    end

    task automatic issue(input logic [1:0] k, input logic [31:0] v, input logic [7:0] p,
                         input bit pin, input result_t e);
        kind <= k;
        value <= v;
        position <= p;
        pin_valid <= pin;
        pin_res <= e;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer taken at this edge
        case (k)
            irsb_pkg::KIND_APPEND: if (drv_len < DEPTH) drv_len++;
            irsb_pkg::KIND_REMOVE: if (int'(p) < drv_len) drv_len--;
            irsb_pkg::KIND_CLEAR:  drv_len = 0;
            default: ;
        endcase
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    initial
    begin
        plan_row_t plan [$];
        plan_row_t row;
        logic [1:0]  k;
        logic [31:0] v;
        logic [7:0]  p;
        int          pick;
        bit          growing;
        int          n;

        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_NULL, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_CLEAR, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(KIND_NOP, 32'hFFFF_FFFF, 8'hFF, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'hFFFF_FFFF, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd1));
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd2));
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'hA5A5_A5A5, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd3));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd3, 1, 1,
                                irsb_pkg::STATUS_NULL, 32'h0, 7'd3));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'hFF, 1, 1,
                                irsb_pkg::STATUS_NULL, 32'h0, 7'd3));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd1, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd2));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'hFFFF_FFFF, 7'd1));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'hA5A5_A5A5, 7'd0));
        // fill to the brim, value steps per rep
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'h1000_0000, 8'd0, DEPTH, 0,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'h5555_5555, 8'd0, 1, 1,
                                irsb_pkg::STATUS_FULL, 32'h0, 7'd64));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd63, 1, 0,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_APPEND, 32'h3C3C_3C3C, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd64));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd0, 1, 0,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd31, 1, 0,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd62, 1, 1,
                                irsb_pkg::STATUS_NULL, 32'h0, 7'd62));
        plan.push_back(plan_row(KIND_NOP, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd62));
        plan.push_back(plan_row(irsb_pkg::KIND_CLEAR, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_DONE, 32'h0, 7'd0));
        plan.push_back(plan_row(irsb_pkg::KIND_REMOVE, 32'h0, 8'd0, 1, 1,
                                irsb_pkg::STATUS_NULL, 32'h0, 7'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            for (int r = 0; r < row.reps; r++)
                issue(row.kind, row.value + 32'(r), row.position, row.pinned, row.res);
        end

        // phases: back to back, sender idle 53%, receiver phase (no stall possible), 27%
        growing = 1'b1;
        n = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 53 : (ph == 3) ? 27 : 0;
            repeat (437)
            begin
                if (n % 200 == 0)
                    growing = ~growing;
                n++;
                pick = $urandom_range(999, 0);
                if (pick < (growing ? 700 : 300))
                    k = irsb_pkg::KIND_APPEND;
                else if (pick < 985)
                    k = irsb_pkg::KIND_REMOVE;
                else if (pick < 990)
                    k = irsb_pkg::KIND_CLEAR;
                else
                    k = KIND_NOP;
                pick = $urandom_range(99, 0);
                v = (pick < 5) ? 32'h0 : (pick < 10) ? 32'hFFFF_FFFF : $urandom;
                if (drv_len > 0 && $urandom_range(99, 0) < 85)
                    p = 8'($urandom_range(drv_len - 1, 0));
                else
                    p = 8'($urandom_range(255, 0));
                issue(k, v, p, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // wait long enough for the longest remove to finish
        repeat (DEPTH + 16) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
